// ----- rtl/bsp_pkg.sv -----
`timescale 1ns / 1ps
package bsp_pkg;

  localparam int unsigned MaxWidth  = 4096;
  localparam int unsigned MaxHeight = 4096;

  localparam logic [1:0] KIND_PIXEL    = 2'd0;
  localparam logic [1:0] KIND_INFO     = 2'd1;
  localparam logic [1:0] KIND_ERROR    = 2'd2;
  localparam logic [1:0] KIND_COMPLETE = 2'd3;

  localparam logic [2:0] ERR_MAGIC    = 3'd0;
  localparam logic [2:0] ERR_DIB      = 3'd1;
  localparam logic [2:0] ERR_PLANES   = 3'd2;
  localparam logic [2:0] ERR_COMPRESS = 3'd3;
  localparam logic [2:0] ERR_OFFSET   = 3'd4;
  localparam logic [2:0] ERR_SIZE     = 3'd5;
  localparam logic [2:0] ERR_EARLY    = 3'd6;

  localparam logic [1:0] ORDER_FILE = 2'd0;
  localparam logic [1:0] ORDER_RGBA = 2'd1;
  localparam logic [1:0] ORDER_BGRA = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [25:0] byte_offset;
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic [5:0]  bits_per_pixel;
    logic [14:0] row_stride;
    logic [2:0]  error_code;
    logic        last;
  } result_t;

endpackage

// ----- rtl/bsp_parser.sv -----
`timescale 1ns / 1ps
module bsp_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  input  logic              start_file,
  input  logic              end_file,
  input  logic [1:0]        color_order,
  output logic [1:0]        res_count,
  output bsp_pkg::result_t  res0,
  output bsp_pkg::result_t  res1
);

  typedef enum logic [2:0] {
    PH_HDR, PH_SKIP, PH_DATA, PH_DONE, PH_ERR
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic [31:0] fs_r, fs_nxt;
  logic [31:0] dstart_r, dstart_nxt;
  logic        hs52_r, hs52_nxt, hs56_r, hs56_nxt;
  logic [12:0] width_r, width_nxt, height_r, height_nxt;
  logic [5:0]  depth_r, depth_nxt;
  logic        big_r, big_nxt;
  logic        bf_r, bf_nxt, flip_r, flip_nxt;
  logic [4:0]  sh_r [4];
  logic [4:0]  sh_nxt [4];
  logic [12:0] row_r, row_nxt;
  logic [14:0] col_r, col_nxt;
  logic [1:0]  c3_r, c3_nxt;
  logic [23:0] pix_r, pix_nxt;
  logic [25:0] rbase_r, rbase_nxt;
  logic [14:0] stride_r;
  logic [15:0] w3_r;
  logic [18:0] bits;
  logic [27:0] prod;

  bsp_pkg::result_t res [2];
  logic [1:0]  n;
  logic [1:0]  co;
  logic [31:0] p, w, tz;
  logic [7:0]  cr, cg, cb, ca;
  logic [14:0] off;
  logic        fin, err;
  logic [2:0]  ecode;
  logic [15:0] colp1;

  assign bits = 19'(depth_r) * 19'(width_r);
  assign prod = 28'(height_r - 13'd1) * 28'(stride_r);

  function automatic bsp_pkg::result_t mk(input logic [1:0] k, input logic [25:0] o,
                                          input logic [31:0] d, input logic [2:0] c,
                                          input logic [2:0] e);
    bsp_pkg::result_t r;
    r = '0;
    r.kind = k;
    r.byte_offset = o;
    r.data_word = d;
    r.byte_count = c;
    r.error_code = e;
    return r;
  endfunction

  always_comb begin
    co = (color_order == 2'd3) ? bsp_pkg::ORDER_FILE : color_order;
    res[0] = '0;
    res[1] = '0;
    n = '0;
    fin = 1'b0;
    err = 1'b0;
    ecode = '0;
    p = '0;
    w = '0;
    tz = '0;
    off = '0;
    colp1 = '0;
    cr = '0; cg = '0; cb = '0; ca = '0;
    phase_nxt = phase_r; pos_nxt = pos_r; fs_nxt = fs_r; dstart_nxt = dstart_r;
    hs52_nxt = hs52_r; hs56_nxt = hs56_r; width_nxt = width_r; height_nxt = height_r;
    depth_nxt = depth_r; big_nxt = big_r; bf_nxt = bf_r; flip_nxt = flip_r;
    sh_nxt = sh_r; row_nxt = row_r; col_nxt = col_r; c3_nxt = c3_r; pix_nxt = pix_r;
    rbase_nxt = rbase_r;
    if (accept) begin
      if (start_file) begin
        phase_nxt = PH_HDR; pos_nxt = '0; fs_nxt = '0; dstart_nxt = '0;
        hs52_nxt = 1'b0; hs56_nxt = 1'b0; width_nxt = '0; height_nxt = '0;
        depth_nxt = '0; big_nxt = 1'b0; bf_nxt = 1'b0; flip_nxt = 1'b1;
        sh_nxt[0] = 5'd16; sh_nxt[1] = 5'd8; sh_nxt[2] = 5'd0; sh_nxt[3] = 5'd24;
        row_nxt = '0; col_nxt = '0; c3_nxt = '0; pix_nxt = '0; rbase_nxt = '0;
      end
      if (phase_nxt == PH_HDR) begin
        fs_nxt = {data_byte, fs_nxt[31:8]};
        for (int i = 0; i < 32; i++) begin
          if (fs_nxt[31 - i]) tz = 32'(31 - i);
        end
        unique case (pos_nxt)
          32'd1: if (fs_nxt[31:16] != 16'h4D42) begin err = 1'b1; ecode = bsp_pkg::ERR_MAGIC; end
          32'd13: dstart_nxt = fs_nxt;
          32'd17: begin
            hs52_nxt = fs_nxt >= 32'd52;
            hs56_nxt = fs_nxt >= 32'd56;
            if (fs_nxt < 32'd40) begin err = 1'b1; ecode = bsp_pkg::ERR_DIB; end
          end
          32'd21: begin
            width_nxt = fs_nxt[12:0];
            big_nxt = big_nxt | (fs_nxt > 32'(bsp_pkg::MaxWidth));
          end
          32'd25: begin
            flip_nxt = ~fs_nxt[31];
            w = fs_nxt[31] ? (32'd0 - fs_nxt) : fs_nxt;
            height_nxt = w[12:0];
            big_nxt = big_nxt | (w > 32'(bsp_pkg::MaxHeight));
          end
          32'd27: if (fs_nxt[31:16] != 16'd1) begin err = 1'b1; ecode = bsp_pkg::ERR_PLANES; end
          32'd29: begin
            depth_nxt = fs_nxt[21:16];
            big_nxt = big_nxt | (fs_nxt[31:16] > 16'd32);
          end
          32'd33: begin
            if (fs_nxt == 32'd3 && hs52_nxt) bf_nxt = 1'b1;
            else if (fs_nxt != 32'd0) begin err = 1'b1; ecode = bsp_pkg::ERR_COMPRESS; end
            else fin = 1'b1;
          end
          32'd57: if (bf_nxt) sh_nxt[0] = tz[4:0];
          32'd61: if (bf_nxt) sh_nxt[1] = tz[4:0];
          32'd65: if (bf_nxt) begin sh_nxt[2] = tz[4:0]; fin = !hs56_nxt; end
          32'd69: if (bf_nxt) begin sh_nxt[3] = tz[4:0]; fin = 1'b1; end
          default: ;
        endcase
        if (fin) begin
          if (big_nxt) begin err = 1'b1; ecode = bsp_pkg::ERR_SIZE; end
          else if (dstart_nxt <= pos_nxt) begin err = 1'b1; ecode = bsp_pkg::ERR_OFFSET; end
          else begin
            res[0] = mk(bsp_pkg::KIND_INFO, '0, '0, '0, '0);
            res[0].image_width = width_nxt;
            res[0].image_height = height_nxt;
            res[0].bits_per_pixel = depth_nxt;
            res[0].row_stride = stride_r;
            n = 2'd1;
            row_nxt = '0; col_nxt = '0; c3_nxt = '0;
            phase_nxt = PH_SKIP;
            if (height_nxt == '0 || stride_r == '0) begin
              phase_nxt = PH_DONE;
              res[1] = mk(bsp_pkg::KIND_COMPLETE, '0, '0, '0, '0);
              n = 2'd2;
            end
            rbase_nxt = flip_nxt ? prod[25:0] : '0;
          end
        end
        if (err) begin
          phase_nxt = PH_ERR;
          res[0] = mk(bsp_pkg::KIND_ERROR, '0, '0, '0, ecode);
          n = 2'd1;
        end
      end else if (phase_nxt == PH_SKIP || phase_nxt == PH_DATA) begin
        if (phase_nxt == PH_SKIP && pos_nxt >= dstart_nxt) phase_nxt = PH_DATA;
        if (phase_nxt == PH_DATA) begin
          if (depth_nxt == 6'd32) begin
            unique case (col_nxt[1:0])
              2'd0: pix_nxt = {16'd0, data_byte};
              2'd1: pix_nxt[15:8] = data_byte;
              2'd2: pix_nxt[23:16] = data_byte;
              default: begin
                p = {data_byte, pix_nxt};
                cr = 8'(p >> sh_nxt[0]);
                cg = 8'(p >> sh_nxt[1]);
                cb = 8'(p >> sh_nxt[2]);
                ca = 8'(p >> sh_nxt[3]);
                unique case (co)
                  bsp_pkg::ORDER_RGBA: w = {ca, cb, cg, cr};
                  bsp_pkg::ORDER_BGRA: w = {ca, cr, cg, cb};
                  default: w = p;
                endcase
                res[0] = mk(bsp_pkg::KIND_PIXEL, rbase_nxt + 26'(col_nxt) - 26'd3, w, 3'd4, '0);
                n = 2'd1;
              end
            endcase
          end else if (depth_nxt == 6'd24) begin
            if (16'(col_nxt) < w3_r) begin
              off = (co == bsp_pkg::ORDER_RGBA) ?
                    col_nxt - 15'(c3_nxt) - 15'(c3_nxt) + 15'd2 : col_nxt;
              res[0] = mk(bsp_pkg::KIND_PIXEL, rbase_nxt + 26'(off), 32'(data_byte), 3'd1, '0);
              n = 2'd1;
            end
          end else begin
            res[0] = mk(bsp_pkg::KIND_PIXEL, rbase_nxt + 26'(col_nxt), 32'(data_byte), 3'd1, '0);
            n = 2'd1;
          end
          colp1 = 16'(col_nxt) + 16'd1;
          col_nxt = colp1[14:0];
          c3_nxt = (c3_nxt == 2'd2) ? 2'd0 : c3_nxt + 2'd1;
          if (colp1 >= 16'(stride_r)) begin
            col_nxt = '0;
            c3_nxt = '0;
            row_nxt = row_nxt + 13'd1;
            if (row_nxt >= height_nxt) begin
              phase_nxt = PH_DONE;
              res[n[0]] = mk(bsp_pkg::KIND_COMPLETE, '0, '0, '0, '0);
              n = n + 2'd1;
            end else begin
              rbase_nxt = flip_nxt ? rbase_nxt - 26'(stride_r) : rbase_nxt + 26'(stride_r);
            end
          end
        end
      end
      if (end_file && phase_nxt != PH_DONE && phase_nxt != PH_ERR) begin
        phase_nxt = PH_ERR;
        res[n[0]] = mk(bsp_pkg::KIND_ERROR, '0, '0, '0, bsp_pkg::ERR_EARLY);
        n = n + 2'd1;
      end
      if (pos_nxt != 32'hFFFF_FFFF) pos_nxt = pos_nxt + 32'd1;
      if (n == 2'd1) res[0].last = 1'b1;
      if (n == 2'd2) res[1].last = 1'b1;
    end
  end

  assign res_count = n;
  assign res0 = res[0];
  assign res1 = res[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR; pos_r <= '0; fs_r <= '0; dstart_r <= '0;
      hs52_r <= 1'b0; hs56_r <= 1'b0; width_r <= '0; height_r <= '0;
      depth_r <= '0; big_r <= 1'b0; bf_r <= 1'b0; flip_r <= 1'b1;
      sh_r[0] <= 5'd16; sh_r[1] <= 5'd8; sh_r[2] <= 5'd0; sh_r[3] <= 5'd24;
      row_r <= '0; col_r <= '0; c3_r <= '0; pix_r <= '0; rbase_r <= '0;
      stride_r <= '0; w3_r <= '0;
    end else begin
      phase_r <= phase_nxt; pos_r <= pos_nxt; fs_r <= fs_nxt; dstart_r <= dstart_nxt;
      hs52_r <= hs52_nxt; hs56_r <= hs56_nxt; width_r <= width_nxt;
      height_r <= height_nxt; depth_r <= depth_nxt; big_r <= big_nxt; bf_r <= bf_nxt;
      flip_r <= flip_nxt; sh_r <= sh_nxt; row_r <= row_nxt; col_r <= col_nxt;
      c3_r <= c3_nxt; pix_r <= pix_nxt; rbase_r <= rbase_nxt;
      stride_r <= 15'(((20'(bits) + 20'd31) >> 5) << 2);
      w3_r <= 16'(width_r) * 16'd3;
    end
  end

endmodule

// ----- rtl/bsp_out_fifo.sv -----
`timescale 1ns / 1ps
module bsp_out_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [1:0]       push_count,
  input  bsp_pkg::result_t push0,
  input  bsp_pkg::result_t push1,
  output logic             room,
  output logic             out_valid,
  input  logic             out_ready,
  output bsp_pkg::result_t head
);

  bsp_pkg::result_t mem_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = cnt_r != 3'd0;
  assign room      = cnt_r <= 3'd2;
  assign head      = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) mem_r[wp_r] <= push0;
    if (push_count == 2'd2) mem_r[wp_r + 2'd1] <= push1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      wp_r <= wp_r + push_count;
      rp_r <= rp_r + 2'(pop);
      cnt_r <= cnt_r + 3'(push_count) - 3'(pop);
    end
  end

endmodule

// ----- rtl/bmp_stream_pixel_unpacker_core.sv -----
`timescale 1ns / 1ps
// channel | direction | handshake     | payload
// in      | input     | valid/ready   | data_byte, start_file, end_file
// out     | output    | valid/ready   | kind .. last (one port each)
// cfg     | input     | we, no wait   | color_order
// One byte per cycle; each byte is parsed in the cycle it is taken and its
// 0 to 2 results land in a 4-entry output queue, visible the next cycle.
// in_ready drops only while the queue holds more than two results.
// Reset (rst_n low, synchronous) empties the queue and restarts the parser.
module bmp_stream_pixel_unpacker_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_start_file,
  input  logic        in_end_file,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [25:0] out_byte_offset,
  output logic [31:0] out_data_word,
  output logic [2:0]  out_byte_count,
  output logic [12:0] out_image_width,
  output logic [12:0] out_image_height,
  output logic [5:0]  out_bits_per_pixel,
  output logic [14:0] out_row_stride,
  output logic [2:0]  out_error_code,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata
);

  logic [1:0]       order_r;
  logic [1:0]       cnt;
  bsp_pkg::result_t r0, r1, head;

  always_ff @(posedge clk) begin
    if (!rst_n) order_r <= bsp_pkg::ORDER_FILE;
    else if (cfg_we) order_r <= cfg_wdata;
  end

  bsp_parser u_parser (
    .clk(clk), .rst_n(rst_n), .accept(in_valid && in_ready),
    .data_byte(in_data_byte), .start_file(in_start_file), .end_file(in_end_file),
    .color_order(order_r), .res_count(cnt), .res0(r0), .res1(r1)
  );

  bsp_out_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push_count(cnt), .push0(r0), .push1(r1),
    .room(in_ready), .out_valid(out_valid), .out_ready(out_ready), .head(head)
  );

  assign out_kind           = head.kind;
  assign out_byte_offset    = head.byte_offset;
  assign out_data_word      = head.data_word;
  assign out_byte_count     = head.byte_count;
  assign out_image_width    = head.image_width;
  assign out_image_height   = head.image_height;
  assign out_bits_per_pixel = head.bits_per_pixel;
  assign out_row_stride     = head.row_stride;
  assign out_error_code     = head.error_code;
  assign out_last           = head.last;

endmodule

// ----- rtl/bsp_checker.sv -----
`timescale 1ns / 1ps
module bsp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [2:0] out_byte_count,
  input logic [2:0] out_error_code
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("out item dropped");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("valid after reset");

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != bsp_pkg::KIND_PIXEL |-> out_byte_count == 3'd0)
    else $error("byte count on non-data item");

  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != bsp_pkg::KIND_ERROR |-> out_error_code == 3'd0)
    else $error("error code on non-error item");

endmodule

bind bmp_stream_pixel_unpacker_core bsp_checker u_bsp_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
  .out_kind(out_kind), .out_byte_count(out_byte_count), .out_error_code(out_error_code)
);
